// ===== rtl/euclidean_mst_length_top_macros.svh =====
// assertion macros shared by the euclidean mst length rtl
// expects signals named clk and rst in the including module
`ifndef EUCLIDEAN_MST_LENGTH_TOP_MACROS_SVH
`define EUCLIDEAN_MST_LENGTH_TOP_MACROS_SVH
// same-cycle implication
`define EMSTL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define EMSTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/emstl_pkg.sv =====
// types, constants and control structs for the euclidean mst length block
// no dependencies
package emstl_pkg;
  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int ROOT_W     = (D2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W + 1);
  localparam int LEN_W      = 32;
  localparam int TOTAL_W    = 7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic [LEN_W-1:0]   tree_length;
    logic [TOTAL_W-1:0] point_total;
  } result_t;

  typedef struct packed {
    logic load;       // store an accepted point
    logic rd_sel_u;   // read address is the newly joined point
    logic cap_u;      // capture joined point coordinates
    logic scan_clr;   // restart the scan
    logic calc_diff;
    logic calc_sq;
    logic upd;        // distance update for scan index
    logic tree_init;
    logic add_tree;   // join best point, start root
    logic acc_add;
    logic out_set;
  } cmd_t;

  typedef struct packed {
    logic n_one;
    logic j_last;
    logic edges_done;
    logic root_done;
    logic out_busy;
  } status_t;
endpackage

// ===== rtl/emstl_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module emstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/emstl_sqrt.sv =====
// bit-serial scaled square root: floor(sqrt(value) * 2^FRAC_BITS)
// depends on emstl_pkg
module emstl_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [emstl_pkg::D2_W-1:0]    value,
  output logic                          done,
  output logic [emstl_pkg::ROOT_W-1:0]  root
);
  localparam int RAD_W = 2 * emstl_pkg::ROOT_W;

  logic [RAD_W-1:0]                rad;
  logic [emstl_pkg::REM_W-1:0]     rem;
  logic [emstl_pkg::STEP_W-1:0]    cnt;
  logic                            run;
  logic [emstl_pkg::REM_W-1:0]     rem_sh;
  logic [emstl_pkg::REM_W-1:0]     trial;
  logic                            take;

  // one result bit per step
  always_comb begin
    rem_sh = {rem[emstl_pkg::REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = emstl_pkg::REM_W'({root, 2'b01});
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= emstl_pkg::STEP_W'(emstl_pkg::ROOT_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == emstl_pkg::STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath of the root unit
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(value) << (2 * emstl_pkg::FRAC_BITS);
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad  <= rad << 2;
      rem  <= take ? rem_sh - trial : rem_sh;
      root <= {root[emstl_pkg::ROOT_W-2:0], take};
    end
  end
endmodule

// ===== rtl/emstl_datapath.sv =====
// datapath: point stores, distance scan, root unit, total and result register
// depends on emstl_pkg, emstl_ram, emstl_sqrt
module emstl_datapath (
  input  logic               clk,
  input  logic               rst,
  input  emstl_pkg::cmd_t    cmd,
  output emstl_pkg::status_t st,
  input  emstl_pkg::point_t  point,
  output emstl_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_stall
);
  logic [emstl_pkg::COUNT_W-1:0]        count;
  logic [emstl_pkg::COUNT_W-1:0]        edges;
  logic [emstl_pkg::IDX_W-1:0]          j;
  logic [emstl_pkg::IDX_W-1:0]          bestj;
  logic [emstl_pkg::D2_W-1:0]           best;
  logic                                 first;
  logic [emstl_pkg::MAX_POINTS-1:0]     in_tree;
  logic signed [emstl_pkg::COORD_W-1:0] xu, yu;
  logic signed [emstl_pkg::COORD_W:0]   dx, dy;
  logic [emstl_pkg::SQ_W-1:0]           sqx, sqy;
  logic [emstl_pkg::LEN_W-1:0]          acc;
  logic [emstl_pkg::COORD_W-1:0]        xr, yr;
  logic [emstl_pkg::D2_W-1:0]           dist_r;
  logic [emstl_pkg::IDX_W-1:0]          raddr;
  logic                                 we_pt;
  logic [emstl_pkg::D2_W-1:0]           d2, cand;
  logic                                 dist_we;
  logic [emstl_pkg::ROOT_W-1:0]         root;
  logic                                 root_done;
  logic [emstl_pkg::LEN_W:0]            sum;
  logic signed [2*emstl_pkg::COORD_W+1:0] px, py;

  assign we_pt = cmd.load && (count < emstl_pkg::COUNT_W'(emstl_pkg::MAX_POINTS));
  assign raddr = cmd.rd_sel_u ? bestj : j;

  emstl_ram #(.WIDTH(emstl_pkg::COORD_W), .DEPTH(emstl_pkg::MAX_POINTS)) u_xram (
    .clk, .we(we_pt), .waddr(count[emstl_pkg::IDX_W-1:0]), .wdata(point.point_x),
    .raddr, .rdata(xr)
  );
  emstl_ram #(.WIDTH(emstl_pkg::COORD_W), .DEPTH(emstl_pkg::MAX_POINTS)) u_yram (
    .clk, .we(we_pt), .waddr(count[emstl_pkg::IDX_W-1:0]), .wdata(point.point_y),
    .raddr, .rdata(yr)
  );

  // candidate distance for the scan index
  always_comb begin
    d2      = emstl_pkg::D2_W'(sqx) + emstl_pkg::D2_W'(sqy);
    cand    = (first || d2 < dist_r) ? d2 : dist_r;
    dist_we = cmd.upd && !in_tree[j];
    px      = dx * dx;
    py      = dy * dy;
    sum     = {1'b0, acc} + (emstl_pkg::LEN_W + 1)'(root);
  end

  emstl_ram #(.WIDTH(emstl_pkg::D2_W), .DEPTH(emstl_pkg::MAX_POINTS)) u_dram (
    .clk, .we(dist_we), .waddr(j), .wdata(cand), .raddr(j), .rdata(dist_r)
  );

  emstl_sqrt u_sqrt (
    .clk, .rst, .start(cmd.add_tree), .value(best), .done(root_done), .root
  );

  // scan arithmetic
  always_ff @(posedge clk) begin
    if (cmd.cap_u) begin
      xu <= xr;
      yu <= yr;
    end
    if (cmd.calc_diff) begin
      dx <= (emstl_pkg::COORD_W+1)'(signed'(xr)) - (emstl_pkg::COORD_W+1)'(xu);
      dy <= (emstl_pkg::COORD_W+1)'(signed'(yr)) - (emstl_pkg::COORD_W+1)'(yu);
    end
    if (cmd.calc_sq) begin
      sqx <= px[emstl_pkg::SQ_W-1:0];
      sqy <= py[emstl_pkg::SQ_W-1:0];
    end
  end

  // control registers of the tree build
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      edges        <= '0;
      j            <= '0;
      bestj        <= '0;
      best         <= '1;
      first        <= 1'b1;
      in_tree      <= '0;
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (we_pt) begin
        count <= count + 1'b1;
      end
      if (cmd.tree_init) begin
        in_tree <= emstl_pkg::MAX_POINTS'(1);
        bestj   <= '0;
        first   <= 1'b1;
        edges   <= '0;
        acc     <= '0;
      end
      if (cmd.scan_clr) begin
        j    <= '0;
        best <= '1;
      end
      if (cmd.upd) begin
        j <= j + 1'b1;
        if (!in_tree[j] && cand < best) begin
          best  <= cand;
          bestj <= j;
        end
      end
      if (cmd.add_tree) begin
        in_tree[bestj] <= 1'b1;
        first          <= 1'b0;
        edges          <= edges + 1'b1;
      end
      if (cmd.acc_add) begin
        acc <= sum[emstl_pkg::LEN_W] ? '1 : sum[emstl_pkg::LEN_W-1:0];
      end
      // result register, freed when its beat is taken
      if (cmd.out_set) begin
        result.tree_length <= acc;
        result.point_total <= emstl_pkg::TOTAL_W'(count);
        result_valid       <= 1'b1;
        count              <= '0;
        acc                <= '0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    st.n_one      = count == emstl_pkg::COUNT_W'(1);
    st.j_last     = emstl_pkg::COUNT_W'(j) == count - 1'b1;
    st.edges_done = edges == count - 1'b1;
    st.root_done  = root_done;
    st.out_busy   = result_valid;
  end
endmodule

// ===== rtl/emstl_ctrl.sv =====
// controller: sequences loading, prim scan, root and result hand-off
// depends on emstl_pkg and the macro header
`include "euclidean_mst_length_top_macros.svh"
module emstl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  input  logic               last,
  output logic               point_stall,
  input  emstl_pkg::status_t st,
  output emstl_pkg::cmd_t    cmd
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_URD   = 4'd2;
  localparam logic [3:0] S_UCAP  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_ROOT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state, state_next;
  logic       accept;

  assign point_stall = state != S_LOAD;
  assign accept      = point_valid && !point_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    case (state)
      S_LOAD: begin
        if (accept && last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.n_one) begin
          state_next = S_OUT;
        end else begin
          cmd.tree_init = 1'b1;
          state_next    = S_URD;
        end
      end
      S_URD: begin
        cmd.rd_sel_u = 1'b1;
        state_next   = S_UCAP;
      end
      S_UCAP: begin
        cmd.cap_u    = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next   = S_RD;
      end
      S_RD:   state_next = S_DIFF;
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.calc_sq = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = st.j_last ? S_ADD : S_RD;
      end
      S_ADD: begin
        cmd.add_tree = 1'b1;
        state_next   = S_ROOT;
      end
      S_ROOT: begin
        if (st.root_done) begin
          cmd.acc_add = 1'b1;
          state_next  = st.edges_done ? S_OUT : S_URD;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_set = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  `EMSTL_ASSERT_NEXT(a_upd_add, state == S_UPD && st.j_last, state == S_ADD, "scan end missed")
  `EMSTL_ASSERT_IMPL(a_out_free, cmd.out_set, !st.out_busy, "result overwritten")
  `EMSTL_ASSERT_IMPL(a_add_edges, state == S_ADD, !st.edges_done, "too many tree edges")
endmodule

// ===== rtl/euclidean_mst_length_top.sv =====
// channel  | beat     | handshake
// point    | point_t  | point_valid / point_stall
// result   | result_t | result_valid / result_stall
//
// points load one per cycle while point_stall is low, in the load state; after the last
// point the prim scan reads each stored point once per tree edge, and each joined
// edge then waits on the bit-serial root unit before its length joins the total
// rst is synchronous and active high; no clearing pass is needed
// a waiting result does not block loading of the next set
// depends on emstl_pkg, emstl_ctrl, emstl_datapath
module euclidean_mst_length_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  emstl_pkg::point_t  point,
  output logic               result_valid,
  input  logic               result_stall,
  output emstl_pkg::result_t result
);
  emstl_pkg::cmd_t    cmd;
  emstl_pkg::status_t st;

  emstl_ctrl u_ctrl (
    .clk, .rst, .point_valid, .last(point.last_point), .point_stall, .st, .cmd
  );

  emstl_datapath u_dp (
    .clk, .rst, .cmd, .st, .point, .result, .result_valid, .result_stall
  );
endmodule

// ===== test/emstl_checker.sv =====
// checker for the euclidean mst length block: watches point and result beats
// depends on emstl_pkg; predicts each tree length and compares it field by field
`timescale 1ns / 100ps
module emstl_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  input  logic               point_stall,
  input  emstl_pkg::point_t  point,
  input  logic               result_valid,
  input  logic               result_stall,
  input  emstl_pkg::result_t result,
  output int                 fail_count,
  output int                 pending_count
);
  import emstl_pkg::*;

  typedef struct {
    logic [63:0] key;
    int          pa;
    int          pb;
  } edge_t;

  logic signed [COORD_W-1:0] xs [MAX_POINTS];
  logic signed [COORD_W-1:0] ys [MAX_POINTS];
  int                        held;
  result_t                   expected_q [$];

  // floor(sqrt(d2) * 2^FRAC_BITS), exact by digit recurrence
  function automatic logic [63:0] scaled_sqrt(input logic [63:0] d2);
    logic [63:0] rem, r, bit_v, r4, t;
    rem = d2;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    for (int k = 0; k < FRAC_BITS; k++) begin
      r4 = rem << 2;
      t = (r << 2) + 1;
      if (r4 >= t) begin
        r = (r << 1) + 1;
        rem = r4 - t;
      end else begin
        r = r << 1;
        rem = r4;
      end
    end
    return r;
  endfunction

  function automatic int find_root(ref int up [MAX_POINTS], input int node);
    while (up[node] != node) node = up[node];
    return node;
  endfunction

  // kruskal over all pairs, sum saturating at 32 bits
  function automatic logic [31:0] tree_sum(input int n);
    edge_t       edges [$];
    edge_t       e;
    int          up [MAX_POINTS];
    longint      dx, dy;
    logic [63:0] acc;
    int          ra, rb;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      up[i] = i;
      for (int j = i + 1; j < n; j++) begin
        dx = longint'(xs[i]) - longint'(xs[j]);
        dy = longint'(ys[i]) - longint'(ys[j]);
        e.key = dx * dx + dy * dy;
        e.pa = i;
        e.pb = j;
        edges = {edges, e};
      end
    end
    edges.sort(x) with (x.key);
    foreach (edges[k]) begin
      ra = find_root(up, edges[k].pa);
      rb = find_root(up, edges[k].pb);
      if (ra != rb) begin
        up[ra] = rb;
        acc = acc + scaled_sqrt(edges[k].key);
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
    end
    return acc[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count = fail_count + 1;
  endtask

  assign pending_count = expected_q.size();

  initial fail_count = 0;

  // point beats: store, and on the closing beat predict the set's total
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      held = 0;
    end else if (point_valid && !point_stall) begin
      if (held < MAX_POINTS) begin
        xs[held] = point.point_x;
        ys[held] = point.point_y;
        held++;
      end
      if (point.last_point) begin
        r.tree_length = tree_sum(held);
        r.point_total = TOTAL_W'(held);
        expected_q = {expected_q, r};
        held = 0;
      end
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", result.tree_length, 32'd0);
      end else begin
        w = expected_q.pop_front();
        if (result.tree_length !== w.tree_length)
          report_mismatch("tree_length", result.tree_length, w.tree_length);
        if (result.point_total !== w.point_total)
          report_mismatch("point_total", 32'(result.point_total), 32'(w.point_total));
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
// stimulus and verdict for euclidean_mst_length_top
// depends on emstl_pkg, the block's rtl and emstl_checker
`timescale 1ns / 100ps
module tb_top;
  import emstl_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic    clk;
  logic    rst;
  logic    point_valid;
  logic    point_stall;
  point_t  point;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      fail_count;
  int      pending_count;
  int      sent;
  bit      calm;
  int      quiet_cycles;

  euclidean_mst_length_top u_top (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  emstl_checker u_checker (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls in random bursts, none in the last part
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((point_valid && !point_stall) || (result_valid && !result_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("** euclidean_mst_length_top: FAILED **");
        $finish;
      end
    end
  end

  // one point beat, with an optional sender gap ahead of it
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    point.point_x <= x;
    point.point_y <= y;
    point.last_point <= last;
    point_valid <= 1'b1;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] rand_coord(input int mode);
    case (mode)
      0: return 16'($urandom_range(0, 15)) - 16'd8;
      1: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // a set of n points; most sizes small, a few at or past the store
  task automatic send_set(input int n);
    int mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  initial begin
    int n;
    rst = 1'b1;
    point_valid = 1'b0;
    point = '0;
    calm = 1'b0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single points, extreme coordinates and repeated points
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(-16'sd32768, 16'sd32767, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    // equal keys on a unit square
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);

    // full store, then extra points dropped, flag on a dropped point
    for (int i = 0; i < 70; i++)
      send_point(16'($urandom), 16'($urandom), i == 69);
    send_set(64);

    while (sent < 1950) begin
      if (sent > 1700) calm = 1'b1;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 10);
      send_set(n);
    end
    point_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("** euclidean_mst_length_top: PASSED **");
    else
      $display("** euclidean_mst_length_top: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/emstl_pkg.sv
rtl/emstl_ram.sv
rtl/emstl_sqrt.sv
rtl/emstl_datapath.sv
rtl/emstl_ctrl.sv
rtl/euclidean_mst_length_top.sv
test/emstl_checker.sv
test/tb_top.sv
